>>> hw/rtl/mie_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mie_pkg;

    // fixed widths of the item fields
    localparam int FIELD_W  = 63;
    localparam int STATUS_W = 2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ZERO  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOINV = 2'd2;

    // sequencer states
    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_START  = 6'b000010,
        S_ALIGN  = 6'b000100,
        S_SUB    = 6'b001000,
        S_UPDATE = 6'b010000,
        S_FIN    = 6'b100000
    } state_t;

    // operations of the shared subtract/compare unit
    typedef enum logic [0:0] {
        ALU_ALIGN = 1'b0,
        ALU_SUB   = 1'b1
    } alu_op_t;

endpackage

`default_nettype wire

>>> hw/rtl/mie_alu.sv
`timescale 1ns / 1ps
`default_nettype none

module mie_alu
    import mie_pkg::*;
#(
    parameter int RW = 63
)
(
    input  alu_op_t         op,
    input  logic [RW-1:0]   rem,
    input  logic [RW-1:0]   dvs,
    output logic [RW-1:0]   diff,
    output logic            ge
);

    logic [RW+1:0] sub_b;
    logic [RW+1:0] full;

    // align compares against the doubled divisor, sub against the divisor itself
    // two guard bits keep the sign right when the doubled divisor tops the remainder
    always_comb
    begin
        unique case (op)
            ALU_ALIGN: sub_b = {1'b0, dvs, 1'b0};
            ALU_SUB:   sub_b = {2'b00, dvs};
        endcase
        full = {2'b00, rem} - sub_b;
        ge   = ~full[RW+1];
        diff = full[RW-1:0];
    end

endmodule

`default_nettype wire

>>> hw/rtl/modular_inverse_euclid.sv
`timescale 1ns / 1ps
`default_nettype none

// Modular inverse by the extended Euclidean algorithm. A transfer on the input
// channel takes modulus m and value z (low WIDTH-1 bits used); one result
// follows with inverse = z^-1 mod m and status 0, or inverse 0 with status 1
// when z is zero, or status 2 when gcd(m, z) is not one. Each Euclid step
// divides with one shared subtract/compare unit: it shifts the divisor up one
// bit a cycle while its double still fits under the remainder, then takes one
// quotient bit a cycle on the way down while the coefficient is built by
// shift-and-add. One item is in work at a time; in_ready is high only between
// items, while a finished result can sit in the output register until taken.
module modular_inverse_euclid
    import mie_pkg::*;
#(
    parameter int WIDTH = 64
)
(
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   in_valid,
    output logic                  in_ready,
    input  wire  [FIELD_W-1:0]    modulus,
    input  wire  [FIELD_W-1:0]    value,
    output logic                  out_valid,
    input  wire                   out_ready,
    output logic [FIELD_W-1:0]    inverse,
    output logic [STATUS_W-1:0]   status
);

    localparam int RW = WIDTH - 1;
    localparam int CW = WIDTH;
    localparam int KW = $clog2(RW);

    state_t state_reg, state_next;

    logic [RW-1:0] m_reg, m_next;
    logic [RW-1:0] prev_r_reg, prev_r_next;
    logic [RW-1:0] cur_r_reg, cur_r_next;
    logic [RW-1:0] rem_reg, rem_next;
    logic [RW-1:0] d_reg, d_next;
    logic [CW-1:0] prev_c_reg, prev_c_next;
    logic [CW-1:0] cur_c_reg, cur_c_next;
    logic [CW-1:0] t_reg, t_next;
    logic [KW-1:0] k_reg, k_next;
    logic          zero_reg, zero_next;

    logic                 out_valid_reg, out_valid_next;
    logic [FIELD_W-1:0]   inverse_reg, inverse_next;
    logic [STATUS_W-1:0]  status_reg, status_next;

    alu_op_t       alu_op;
    logic [RW-1:0] alu_diff;
    logic          alu_ge;
    logic [CW-1:0] coef_fix;

    // shared subtract/compare unit
    assign alu_op = (state_reg == S_ALIGN) ? ALU_ALIGN : ALU_SUB;

    mie_alu #(
        .RW (RW)
    ) u_alu (
        .op   (alu_op),
        .rem  (rem_reg),
        .dvs  (d_reg),
        .diff (alu_diff),
        .ge   (alu_ge)
    );

    // negative coefficient brought into range
    assign coef_fix = prev_c_reg[CW-1] ? (prev_c_reg + {1'b0, m_reg}) : prev_c_reg;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign inverse   = inverse_reg;
    assign status    = status_reg;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        m_next         = m_reg;
        prev_r_next    = prev_r_reg;
        cur_r_next     = cur_r_reg;
        rem_next       = rem_reg;
        d_next         = d_reg;
        prev_c_next    = prev_c_reg;
        cur_c_next     = cur_c_reg;
        t_next         = t_reg;
        k_next         = k_reg;
        zero_next      = zero_reg;
        out_valid_next = out_valid_reg;
        inverse_next   = inverse_reg;
        status_next    = status_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    m_next      = modulus[RW-1:0];
                    prev_r_next = modulus[RW-1:0];
                    cur_r_next  = value[RW-1:0];
                    prev_c_next = '0;
                    cur_c_next  = CW'(1);
                    zero_next   = (value[RW-1:0] == '0);
                    state_next  = S_START;
                end
            end
            S_START:
            begin
                rem_next = prev_r_reg;
                d_next   = cur_r_reg;
                k_next   = '0;
                t_next   = '0;
                if (zero_reg || (cur_r_reg == '0))
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_ALIGN;
                end
            end
            S_ALIGN:
            begin
                // grow divisor while its double still fits under the remainder
                if (alu_ge)
                begin
                    d_next = {d_reg[RW-2:0], 1'b0};
                    k_next = k_reg + KW'(1);
                end
                else
                begin
                    state_next = S_SUB;
                end
            end
            S_SUB:
            begin
                // one quotient bit, coefficient product by shift-and-add
                if (alu_ge)
                begin
                    rem_next = alu_diff;
                    t_next   = {t_reg[CW-2:0], 1'b0} + cur_c_reg;
                end
                else
                begin
                    t_next   = {t_reg[CW-2:0], 1'b0};
                end
                if (k_reg == '0)
                begin
                    state_next = S_UPDATE;
                end
                else
                begin
                    d_next = {1'b0, d_reg[RW-1:1]};
                    k_next = k_reg - KW'(1);
                end
            end
            S_UPDATE:
            begin
                prev_r_next = cur_r_reg;
                cur_r_next  = rem_reg;
                prev_c_next = cur_c_reg;
                cur_c_next  = prev_c_reg - t_reg;
                state_next  = S_START;
            end
            S_FIN:
            begin
                // load the result once the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    if (zero_reg)
                    begin
                        inverse_next = '0;
                        status_next  = ST_ZERO;
                    end
                    else if (prev_r_reg != RW'(1))
                    begin
                        inverse_next = '0;
                        status_next  = ST_NOINV;
                    end
                    else
                    begin
                        inverse_next = FIELD_W'(coef_fix[RW-1:0]);
                        status_next  = ST_OK;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        m_reg       <= m_next;
        prev_r_reg  <= prev_r_next;
        cur_r_reg   <= cur_r_next;
        rem_reg     <= rem_next;
        d_reg       <= d_next;
        prev_c_reg  <= prev_c_next;
        cur_c_reg   <= cur_c_next;
        t_reg       <= t_next;
        k_reg       <= k_next;
        zero_reg    <= zero_next;
        inverse_reg <= inverse_next;
        status_reg  <= status_next;
    end

    // each Euclid step leaves a remainder below its divisor
    a_rem_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UPDATE) |-> (rem_reg < cur_r_reg))
        else $error("remainder not below divisor at step end");

    // the divisor being aligned is never zero
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ALIGN || state_reg == S_SUB) |-> (d_reg != '0))
        else $error("zero divisor in division");

    // a presented result carries a defined status, inverse zero unless found
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((status_reg == ST_OK)
            || ((status_reg == ST_ZERO || status_reg == ST_NOINV)
                && (inverse_reg == '0))))
        else $error("bad result status");

endmodule

`default_nettype wire
